// ----- rtl/ofsf_pkg.sv -----
// ----------------------------------------------------------------------------
// ofsf_pkg
// Shared types and constants of the Ogg first-stream page filter: result
// kinds, header layout positions and the parser-to-sequencer decision.
// ----------------------------------------------------------------------------
package ofsf_pkg;

   // result kinds carried on rsp_tuser
   localparam logic [1:0] KIND_KEPT    = 2'd0;
   localparam logic [1:0] KIND_DISCARD = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   // header layout
   localparam int unsigned POS_W      = 5;
   localparam int unsigned HOLD_DEPTH = 18;
   localparam int unsigned HOLD_AW    = $clog2(HOLD_DEPTH);
   localparam logic [POS_W-1:0] POS_SIG_LAST    = 5'd3;
   localparam logic [POS_W-1:0] POS_SERIAL      = 5'd14;
   localparam logic [POS_W-1:0] POS_SERIAL_LAST = 5'd17;
   localparam logic [POS_W-1:0] POS_HOLD_END    = 5'd18;
   localparam logic [POS_W-1:0] POS_HDR_LAST    = 5'd26;
   localparam logic [POS_W-1:0] HDR_LEN         = 5'd27;

   localparam int unsigned RSP_TDATA_W = 32;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [1:0]  kind;
      logic        page_end;
      logic [15:0] pages_kept;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic               emit;
      logic               start_burst;
      logic               hold_we;
      logic [HOLD_AW-1:0] hold_addr;
      rsp_type            res;
      logic [15:0]        kept_count;
   } dec_type;

endpackage

// ----- rtl/ofsf_page_parser.sv -----
// ----------------------------------------------------------------------------
// ofsf_page_parser
// Page parser: tracks header position, lacing and payload counts, serial
// match and kept-page count, and decides per item what the sequencer emits.
// ----------------------------------------------------------------------------
module ofsf_page_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        data_byte,
   input  logic              end_of_data,
   output ofsf_pkg::dec_type dec
);

   typedef enum logic [2:0] {
      PH_HEADER  = 3'b001,
      PH_LACING  = 3'b010,
      PH_PAYLOAD = 3'b100
   } phase_type;

   localparam logic [7:0] SIG [4] = '{8'h4F, 8'h67, 8'h67, 8'h53};

   phase_type                     phase_ff, phase_in;
   logic [ofsf_pkg::POS_W-1:0]    hpos_ff, hpos_in;
   logic                          sigbad_ff, sigbad_in;
   logic [31:0]                   first_ff, first_in;
   logic                          known_ff, known_in;
   logic [31:0]                   serial_ff, serial_in;
   logic                          keep_ff, keep_in;
   logic [7:0]                    lace_ff, lace_in;
   logic [16:0]                   pay_ff, pay_in;
   logic [15:0]                   count_ff, count_in;
   logic                          halted_ff, halted_in;

   logic [ofsf_pkg::POS_W-1:0]    pos;
   logic [1:0]                    lane;
   logic [31:0]                   ser_full;
   logic                          bad;
   logic                          done;
   logic [16:0]                   pay_sum;
   logic [16:0]                   pay_dec;
   logic [7:0]                    lace_dec;

   always_comb begin
      phase_in  = phase_ff;
      hpos_in   = hpos_ff;
      sigbad_in = sigbad_ff;
      first_in  = first_ff;
      known_in  = known_ff;
      serial_in = serial_ff;
      keep_in   = keep_ff;
      lace_in   = lace_ff;
      pay_in    = pay_ff;
      count_in  = count_ff;
      halted_in = halted_ff;

      pos      = (hpos_ff >= ofsf_pkg::HDR_LEN) ? ofsf_pkg::POS_HDR_LAST : hpos_ff;
      lane     = 2'(pos - ofsf_pkg::POS_SERIAL);
      ser_full = {data_byte, serial_ff[23:0]};
      pay_sum  = pay_ff + {9'd0, data_byte};
      pay_dec  = pay_ff - 17'd1;
      lace_dec = lace_ff - 8'd1;
      bad      = 1'b0;
      done     = 1'b0;

      dec                = '0;
      dec.kept_count     = count_ff;
      dec.hold_addr      = pos;
      dec.res.kind       = ofsf_pkg::KIND_KEPT;
      dec.res.pages_kept = count_ff;
      dec.res.last       = 1'b1;

      if (accept && !halted_ff) begin
         case (phase_ff)
            PH_LACING: begin
               if (keep_ff) begin
                  dec.emit         = 1'b1;
                  dec.res.out_byte = data_byte;
               end
               pay_in  = pay_sum;
               lace_in = lace_dec;
               if (lace_dec == 8'd0) begin
                  if (pay_sum == 17'd0) begin
                     done = 1'b1;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               if (keep_ff) begin
                  dec.emit         = 1'b1;
                  dec.res.out_byte = data_byte;
               end
               pay_in = pay_dec;
               if (pay_dec == 17'd0) begin
                  done = 1'b1;
               end
            end
            default: begin
               dec.hold_we = (pos < ofsf_pkg::POS_HOLD_END);
               if (pos <= ofsf_pkg::POS_SIG_LAST) begin
                  sigbad_in = ((pos == '0) ? 1'b0 : sigbad_ff) |
                              (data_byte != SIG[pos[1:0]]);
               end
               if (pos == ofsf_pkg::POS_SIG_LAST && sigbad_in) begin
                  // bad signature: report once and stop
                  bad              = 1'b1;
                  halted_in        = 1'b1;
                  dec.emit         = 1'b1;
                  dec.res.kind     = ofsf_pkg::KIND_ERROR;
               end else begin
                  if (pos >= ofsf_pkg::POS_SERIAL && pos <= ofsf_pkg::POS_SERIAL_LAST) begin
                     serial_in[8*lane +: 8] = data_byte;
                  end
                  if (pos == ofsf_pkg::POS_SERIAL_LAST) begin
                     if (!known_ff) begin
                        first_in = ser_full;
                        known_in = 1'b1;
                        keep_in  = 1'b1;
                     end else begin
                        keep_in  = (ser_full == first_ff);
                     end
                     dec.start_burst = keep_in;
                  end else if (pos >= ofsf_pkg::POS_HOLD_END && keep_ff) begin
                     dec.emit         = 1'b1;
                     dec.res.out_byte = data_byte;
                  end
                  if (pos == ofsf_pkg::POS_HDR_LAST) begin
                     hpos_in = '0;
                     lace_in = data_byte;
                     pay_in  = '0;
                     if (data_byte == 8'd0) begin
                        done = 1'b1;
                     end else begin
                        phase_in = PH_LACING;
                     end
                  end else begin
                     hpos_in = pos + 5'd1;
                  end
               end
            end
         endcase

         if (!bad) begin
            if (done) begin
               if (keep_ff && dec.emit) begin
                  count_in = (count_ff != 16'hFFFF) ? count_ff + 16'd1 : count_ff;
                  dec.res.page_end   = 1'b1;
                  dec.res.pages_kept = count_in;
               end
               phase_in = PH_HEADER;
               hpos_in  = '0;
               keep_in  = 1'b0;
               lace_in  = '0;
               pay_in   = '0;
            end
            if (end_of_data) begin
               // truncated page: replace this item's results with a discard marker
               if (!done) begin
                  dec.emit           = 1'b1;
                  dec.start_burst    = 1'b0;
                  dec.res.kind       = ofsf_pkg::KIND_DISCARD;
                  dec.res.out_byte   = '0;
                  dec.res.page_end   = 1'b0;
                  dec.res.pages_kept = count_ff;
               end
               phase_in  = PH_HEADER;
               hpos_in   = '0;
               first_in  = '0;
               known_in  = 1'b0;
               serial_in = '0;
               keep_in   = 1'b0;
               lace_in   = '0;
               pay_in    = '0;
               count_in  = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         hpos_ff   <= '0;
         sigbad_ff <= 1'b0;
         first_ff  <= '0;
         known_ff  <= 1'b0;
         serial_ff <= '0;
         keep_ff   <= 1'b0;
         lace_ff   <= '0;
         pay_ff    <= '0;
         count_ff  <= '0;
         halted_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         hpos_ff   <= hpos_in;
         sigbad_ff <= sigbad_in;
         first_ff  <= first_in;
         known_ff  <= known_in;
         serial_ff <= serial_in;
         keep_ff   <= keep_in;
         lace_ff   <= lace_in;
         pay_ff    <= pay_in;
         count_ff  <= count_in;
         halted_ff <= halted_in;
      end
   end

endmodule

// ----- rtl/ogg_first_stream_page_filter.sv -----
// ----------------------------------------------------------------------------
// ogg_first_stream_page_filter
// Passes through the Ogg pages that carry the first page's serial number.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  takes one byte of the Ogg data region per item; req_tlast marks
//          the last byte of the region.
//   rsp_*  delivers result items: kept page bytes, a discard marker for a
//          truncated page, or a bad signature error (kind on rsp_tuser).
//          rsp_tlast marks the last result caused by one input byte.
// Flow:
//   An ordinary byte gives its result in the cycle after it is taken, and the
//   block takes one byte per cycle while rsp_tready stays high and no header
//   release is under way. Header byte 17 of a kept page releases the 18 held
//   header bytes from the hold memory: each passes through a read state and a
//   show state, and req_tready stays low meanwhile. The hold memory has a
//   single read port with a registered output.
// Reset clears the parser and the output valid flag; after a bad signature the
//   block keeps taking bytes and gives no results until reset.
// A stalled receiver holds the output register; req_tready stays low until
//   the register can take the next result.
// ----------------------------------------------------------------------------
module ogg_first_stream_page_filter (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,   // [7:0] data_byte
   input  logic                             req_tlast,   // end_of_data
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [7:0] out_byte, [8] page_end, [24:9] pages_kept, [31:25] zero
   output logic [ofsf_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic [1:0]                       rsp_tuser,   // [1:0] kind
   output logic                             rsp_tlast    // last
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_SHOW = 3'b100
   } state_type;

   localparam logic [ofsf_pkg::HOLD_AW-1:0] HOLD_LAST =
      ofsf_pkg::HOLD_AW'(ofsf_pkg::HOLD_DEPTH - 1);
   localparam logic [ofsf_pkg::HOLD_AW-1:0] HOLD_STEP = ofsf_pkg::HOLD_AW'(1);

   state_type                       st_ff, st_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [ofsf_pkg::HOLD_AW-1:0]    rd_idx_ff, rd_idx_in;
   ofsf_pkg::rsp_type               rsp_res_ff;
   ofsf_pkg::rsp_type               load_val;
   logic                            load;
   logic [7:0]                      hold_mem [ofsf_pkg::HOLD_DEPTH];
   logic [7:0]                      mem_q_ff;
   logic                            rd_en;
   logic                            slot_free;
   logic                            accept;
   ofsf_pkg::dec_type               dec;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (st_ff == ST_IDLE) && slot_free;
   assign accept     = req_tvalid && req_tready;
   assign rd_en      = (st_ff == ST_READ);

   ofsf_page_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .data_byte   (req_tdata),
      .end_of_data (req_tlast),
      .dec         (dec)
   );

   always_ff @(posedge clock) begin
      if (accept && dec.hold_we) begin
         hold_mem[dec.hold_addr] <= req_tdata;
      end
      if (rd_en) begin
         mem_q_ff <= hold_mem[rd_idx_ff];
      end
   end

   always_comb begin
      st_in        = st_ff;
      rd_idx_in    = rd_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      load         = 1'b0;
      load_val     = dec.res;
      case (st_ff)
         ST_IDLE: begin
            if (accept) begin
               load = dec.emit;
               if (dec.start_burst) begin
                  st_in     = ST_READ;
                  rd_idx_in = '0;
               end
            end
         end
         ST_READ: begin
            st_in = ST_SHOW;
         end
         ST_SHOW: begin
            // release one held header byte when the output register frees up
            if (slot_free) begin
               load                = 1'b1;
               load_val.out_byte   = mem_q_ff;
               load_val.kind       = ofsf_pkg::KIND_KEPT;
               load_val.page_end   = 1'b0;
               load_val.pages_kept = dec.kept_count;
               load_val.last       = (rd_idx_ff == HOLD_LAST);
               if (rd_idx_ff == HOLD_LAST) begin
                  st_in = ST_IDLE;
               end else begin
                  rd_idx_in = rd_idx_ff + HOLD_STEP;
                  st_in     = ST_READ;
               end
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
      if (load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rd_idx_ff    <= '0;
      end else begin
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_idx_ff    <= rd_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_res_ff <= load_val;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_res_ff.pages_kept, rsp_res_ff.page_end,
                        rsp_res_ff.out_byte};
   assign rsp_tuser  = rsp_res_ff.kind;
   assign rsp_tlast  = rsp_res_ff.last;

endmodule

// ----- rtl/ofsf_checker.sv -----
// ----------------------------------------------------------------------------
// ofsf_checker
// Port-level checks of the Ogg first-stream page filter, bound to the top.
// ----------------------------------------------------------------------------
module ofsf_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [ofsf_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [1:0]                       rsp_tuser,
   input logic                             rsp_tlast
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   a_kind_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == ofsf_pkg::KIND_KEPT ||
      rsp_tuser == ofsf_pkg::KIND_DISCARD || rsp_tuser == ofsf_pkg::KIND_ERROR)
      else $error("unknown result kind");

   // markers are single results with no byte and no page end
   a_marker_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ofsf_pkg::KIND_KEPT |->
      rsp_tlast && rsp_tdata[8:0] == 9'd0)
      else $error("marker result carries data or is not last");

   a_page_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[8] |-> rsp_tlast && rsp_tuser == ofsf_pkg::KIND_KEPT)
      else $error("page end not on the last kept byte of an item");

   // an error halts the block: nothing follows it
   a_halt_silent: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tuser == ofsf_pkg::KIND_ERROR |=> !rsp_tvalid)
      else $error("result after bad signature");

endmodule

bind ogg_first_stream_page_filter ofsf_checker u_ofsf_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ----- dv/ogg_first_stream_page_filter_test.sv -----
// ----------------------------------------------------------------------------
// ogg_first_stream_page_filter_test
// Drives Ogg page streams through the first-stream page filter and predicts
// every result item from a byte-level parser. The streams hold empty pages,
// foreign pages, truncated regions and a bad signature. The sender and the
// receiver idle at random, and one long receiver hold-off fills the block.
// ----------------------------------------------------------------------------
module ogg_first_stream_page_filter_test;

   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 60;
   localparam int REPORT_LIMIT    = 40;
   localparam int REGION_BYTES    = 20;
   localparam logic [31:0] OGG_CAPTURE = "OggS";

   typedef enum logic [1:0] {PH_HEADER, PH_LACING, PH_PAYLOAD} parse_phase_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] data_byte
   logic        req_tlast  = 1'b0;    // end_of_data
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [7:0] out_byte, [8] page_end, [24:9] pages_kept
   logic [ofsf_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic [1:0]  rsp_tuser;            // [1:0] kind
   logic        rsp_tlast;            // last

   // stimulus knobs
   int   send_idle_pct = 0;
   int   rsp_stall_pct = 0;
   logic rsp_hold      = 1'b0;
   int   bytes_sent    = 0;

   // parser state of the prediction
   parse_phase_type page_phase = PH_HEADER;
   logic [4:0]   hdr_pos      = '0;
   logic [7:0]   hdr_hold [ofsf_pkg::HOLD_DEPTH];
   logic [31:0]  first_serial = '0;
   bit           serial_known = 1'b0;
   logic [31:0]  page_serial  = '0;
   bit           keep_page    = 1'b0;
   logic [7:0]   lacing_left  = '0;
   logic [16:0]  payload_left = '0;
   logic [15:0]  kept_count   = '0;
   bit           halted       = 1'b0;

   ofsf_pkg::rsp_type filter_out_q[$];
   ofsf_pkg::rsp_type want;
   int      field_errors = 0;
   int      quiet_cycles = 0;

   ogg_first_stream_page_filter uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #2 clock = ~clock;

   function automatic ofsf_pkg::rsp_type page_result(logic [7:0] b, logic [1:0] kind);
      ofsf_pkg::rsp_type r;
      r = '0;
      r.out_byte   = b;
      r.kind       = kind;
      r.pages_kept = kept_count;
      return r;
   endfunction

   // Work out the result items one accepted byte causes and queue them.
   task automatic parse_ogg_byte(input logic [7:0] b, input logic eod);
      ofsf_pkg::rsp_type res[$];
      logic [4:0] pos;
      bit         done;
      int         i;
      done = 1'b0;
      if (halted) return;
      case (page_phase)
         PH_LACING: begin
            if (keep_page) res.push_back(page_result(b, ofsf_pkg::KIND_KEPT));
            payload_left = payload_left + b;
            lacing_left  = lacing_left - 8'd1;
            if (lacing_left == 0) begin
               if (payload_left == 0) done = 1'b1;
               else page_phase = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            if (keep_page) res.push_back(page_result(b, ofsf_pkg::KIND_KEPT));
            payload_left = payload_left - 17'd1;
            if (payload_left == 0) done = 1'b1;
         end
         default: begin
            pos = (hdr_pos >= ofsf_pkg::HDR_LEN) ? ofsf_pkg::POS_HDR_LAST : hdr_pos;
            if (pos < ofsf_pkg::POS_HOLD_END) hdr_hold[pos] = b;
            if (pos == ofsf_pkg::POS_SIG_LAST &&
                {hdr_hold[0], hdr_hold[1], hdr_hold[2], hdr_hold[3]} != OGG_CAPTURE) begin
               // halt: one error item, no region restart even on end of data
               halted = 1'b1;
               want = page_result(8'h00, ofsf_pkg::KIND_ERROR);
               want.last = 1'b1;
               filter_out_q.push_back(want);
               return;
            end
            if (pos == ofsf_pkg::POS_SERIAL_LAST) begin
               page_serial = {hdr_hold[17], hdr_hold[16], hdr_hold[15], hdr_hold[14]};
               if (!serial_known) begin
                  first_serial = page_serial;
                  serial_known = 1'b1;
               end
               keep_page = (page_serial == first_serial);
               if (keep_page)
                  for (i = 0; i < ofsf_pkg::HOLD_DEPTH; i++)
                     res.push_back(page_result(hdr_hold[i], ofsf_pkg::KIND_KEPT));
            end else if (pos >= ofsf_pkg::POS_HOLD_END && keep_page) begin
               res.push_back(page_result(b, ofsf_pkg::KIND_KEPT));
            end
            if (pos == ofsf_pkg::POS_HDR_LAST) begin
               hdr_pos      = '0;
               lacing_left  = b;
               payload_left = '0;
               if (b == 0) done = 1'b1;
               else page_phase = PH_LACING;
            end else begin
               hdr_pos = pos + 5'd1;
            end
         end
      endcase

      if (done) begin
         if (keep_page && res.size() > 0) begin
            if (kept_count != 16'hFFFF) kept_count = kept_count + 16'd1;
            res[res.size()-1].page_end   = 1'b1;
            res[res.size()-1].pages_kept = kept_count;
         end
         page_phase   = PH_HEADER;
         hdr_pos      = '0;
         keep_page    = 1'b0;
         lacing_left  = '0;
         payload_left = '0;
      end

      if (eod) begin
         // a page cut short is replaced by one discard item
         if (!done) begin
            res.delete();
            res.push_back(page_result(8'h00, ofsf_pkg::KIND_DISCARD));
         end
         page_phase   = PH_HEADER;
         hdr_pos      = '0;
         first_serial = '0;
         serial_known = 1'b0;
         page_serial  = '0;
         keep_page    = 1'b0;
         lacing_left  = '0;
         payload_left = '0;
         kept_count   = '0;
      end

      if (res.size() > 0) res[res.size()-1].last = 1'b1;
      foreach (res[j]) filter_out_q.push_back(res[j]);
   endtask

   task automatic check_field(input string field, input logic [31:0] want_v,
                              input logic [31:0] got_v);
      if (want_v !== got_v) begin
         if (field_errors < REPORT_LIMIT)
            $display("%0t: %s expected %0h got %0h", $time, field, want_v, got_v);
         field_errors++;
      end
   endtask

   // predict on each accepted byte, then compare each accepted result
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) parse_ogg_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (filter_out_q.size() == 0) begin
               if (field_errors < REPORT_LIMIT)
                  $display("%0t: result with none due: expected nothing got tdata %0h tuser %0h",
                           $time, rsp_tdata, rsp_tuser);
               field_errors++;
            end else begin
               want = filter_out_q.pop_front();
               check_field("out_byte", want.out_byte, rsp_tdata[7:0]);
               check_field("page_end", want.page_end, rsp_tdata[8]);
               check_field("pages_kept", want.pages_kept, rsp_tdata[24:9]);
               check_field("pad bits", 32'd0, rsp_tdata[31:25]);
               check_field("kind", want.kind, rsp_tuser);
               check_field("last", want.last, rsp_tlast);
            end
         end
      end
   end

   always @(posedge clock)
      rsp_tready <= !rsp_hold && ($urandom_range(99) >= rsp_stall_pct);

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic set_idling(input int send_pct, input int stall_pct);
      send_idle_pct = send_pct;
      rsp_stall_pct <= stall_pct;
   endtask

   // Offer one byte and hold it until the block takes it.
   task automatic send_item(input logic [7:0] b, input logic eod);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eod;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      bytes_sent++;
   endtask

   // Build one page; trunc_at >= 0 cuts it short with end of data on that byte (at most the second-last).
   task automatic send_page(input logic [31:0] serial, input int nseg, input int lace_lo,
                            input int lace_hi, input bit region_end, input int trunc_at);
      logic [7:0] pg[$];
      int         payload_len;
      int         lace;
      int         stop;
      int         k;
      payload_len = 0;
      pg = {OGG_CAPTURE[31:24], OGG_CAPTURE[23:16], OGG_CAPTURE[15:8], OGG_CAPTURE[7:0]};
      repeat (10) pg.push_back(8'($urandom_range(255)));   // version, type, granule
      for (k = 0; k < 4; k++) pg.push_back(serial[8*k +: 8]);
      repeat (8) pg.push_back(8'($urandom_range(255)));    // sequence, checksum
      pg.push_back(8'(nseg));
      repeat (nseg) begin
         lace = $urandom_range(lace_hi, lace_lo);
         pg.push_back(8'(lace));
         payload_len += lace;
      end
      repeat (payload_len) pg.push_back(8'($urandom_range(255)));
      if (trunc_at < 0) stop = pg.size() - 1;
      else stop = (trunc_at > pg.size() - 2) ? pg.size() - 2 : trunc_at;
      for (k = 0; k <= stop; k++)
         send_item(pg[k], (k == stop) && (trunc_at >= 0 || region_end));
   endtask

   // One data region: pages of the first serial mixed with foreign ones,
   // the last page sometimes cut short.
   task automatic send_random_region();
      logic [31:0] first;
      logic [31:0] ser;
      int          npages;
      int          p;
      int          trunc;
      first  = $urandom;
      npages = $urandom_range(1, 2);
      for (p = 0; p < npages; p++) begin
         ser = (p == 0 || $urandom_range(99) < 65) ? first : first ^ ($urandom | 32'd1);
         trunc = -1;
         if (p == npages - 1 && $urandom_range(99) < 25) trunc = int'($urandom_range(45));
         send_page(ser, int'($urandom_range(3)), 0, $urandom_range(1) ? 6 : 2,
                   p == npages - 1, trunc);
      end
   endtask

   task automatic run_regions(input int nbytes);
      int start;
      start = bytes_sent;
      while (bytes_sent - start < nbytes) send_random_region();
   endtask

   task automatic test_empty_pages();
      logic [31:0] s;
      s = $urandom;
      set_idling(0, 0);
      send_page(s, 0, 0, 0, 1'b0, -1);   // ends on the segment count byte
      send_page(s, 2, 0, 0, 1'b1, -1);   // ends on its last lacing byte
   endtask

   task automatic test_foreign_serial();
      logic [31:0] s;
      s = $urandom;
      send_page(s, 1, 1, 3, 1'b0, -1);
      send_page(s ^ 32'h8000_0001, 1, 1, 3, 1'b0, -1);
      send_page(s, 1, 1, 1, 1'b1, -1);
   endtask

   task automatic test_truncation();
      logic [31:0] s;
      s = $urandom;
      send_item(OGG_CAPTURE[31:24], 1'b1);
      send_page(s, 1, 2, 2, 1'b0, 17);   // cut on the serial's last byte
      send_page(s, 1, 2, 2, 1'b0, 3);    // cut on a good signature byte
      send_page(s, 1, 4, 4, 1'b0, 29);   // cut inside the payload of a kept page
   endtask

   task automatic test_sender_gaps();
      set_idling(71, 0);
      run_regions(REGION_BYTES);
   endtask

   task automatic test_receiver_stalls();
      set_idling(0, 71);
      run_regions(REGION_BYTES);
   endtask

   task automatic test_both_idle();
      set_idling(12, 12);
      run_regions(REGION_BYTES);
   endtask

   task automatic test_back_pressure();
      logic [31:0] s;
      s = $urandom;
      set_idling(0, 0);
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_hold <= 1'b0;
         end
      join_none
      send_page(s, 2, 4, 4, 1'b1, -1);
   endtask

   // Last: a bad signature halts the block until reset.
   task automatic test_bad_signature();
      logic [31:0] sig;
      int          k;
      set_idling(0, 0);
      sig = OGG_CAPTURE;
      k = $urandom_range(3);
      sig[8*k +: 8] = sig[8*k +: 8] ^ 8'($urandom_range(255, 1));
      send_item(sig[31:24], 1'b0);
      send_item(sig[23:16], 1'b0);
      send_item(sig[15:8], 1'b0);
      send_item(sig[7:0], 1'($urandom_range(1)));
      // ignored while halted
      repeat (6) send_item(8'($urandom_range(255)), 1'b0);
      send_item(OGG_CAPTURE[31:24], 1'b1);
      send_item(8'($urandom_range(255)), 1'b0);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_empty_pages();
      test_foreign_serial();
      test_truncation();
      test_sender_gaps();
      test_receiver_stalls();
      test_both_idle();
      test_back_pressure();
      test_bad_signature();
      req_tvalid <= 1'b0;
      while (filter_out_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (field_errors == 0 && filter_out_q.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
